### rtl/bedc_pkg.sv
// Package: event codes, register reset value and shared types for the button event block.
`timescale 1ns / 1ps

package bedc_pkg;

    localparam int unsigned NUM_BUTTONS = 3;
    localparam int unsigned EVENT_BITS  = 3;
    localparam int unsigned COUNT_BITS  = 2;
    localparam int unsigned STAMP_BITS  = 32;

    typedef logic [EVENT_BITS-1:0] t_event;
    typedef logic [COUNT_BITS-1:0] t_count;

    localparam t_event EV_NONE   = 3'd0;
    localparam t_event EV_DOWN   = 3'd1;
    localparam t_event EV_UP     = 3'd2;
    localparam t_event EV_HELD   = 3'd3;
    localparam t_event EV_DOUBLE = 3'd4;

    localparam t_count COUNT_IDLE  = 2'd0;
    localparam t_count COUNT_ONE   = 2'd1;
    localparam t_count COUNT_TWO   = 2'd2;

    localparam logic [STAMP_BITS-1:0] DCT_RESET = 32'd500;

    typedef struct packed {
        logic was;
        logic is_down;
        logic adv;
    } t_btn_ctl;

endpackage

### rtl/bedc_if.sv
// Interfaces: poll input, event output and configuration write channels.
`timescale 1ns / 1ps

interface bedc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  buttons;
    logic [31:0] now_ms;

    modport source (output valid, output buttons, output now_ms, input ready);
    modport sink (input valid, input buttons, input now_ms, output ready);
endinterface

interface bedc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] left_event;
    logic [2:0] right_event;
    logic [2:0] middle_event;

    modport source (output valid, output left_event, output right_event,
                    output middle_event, input ready);
    modport sink (input valid, input left_event, input right_event,
                  input middle_event, output ready);
endinterface

interface bedc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/bedc_button.sv
// Per-button edge classifier with click count and double-click timing.
`timescale 1ns / 1ps

module bedc_button
    import bedc_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_btn_ctl              i_ctl,
    input  logic [TIME_BITS-1:0]  i_now,
    input  logic [STAMP_BITS-1:0] i_dct,
    output t_event                o_event
);

    localparam int CMP_BITS = (TIME_BITS > STAMP_BITS) ? TIME_BITS : STAMP_BITS;

    t_count               r_count;
    t_count               n_count;
    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] n_start;
    logic [TIME_BITS-1:0] w_elapsed;
    logic [CMP_BITS-1:0]  w_elapsed_ext;
    logic [CMP_BITS-1:0]  w_dct_ext;
    logic                 w_stale;
    logic                 w_within;
    t_count               w_cnt_clr;
    t_event               w_edge;

    assign w_elapsed     = i_now - r_start;
    assign w_elapsed_ext = CMP_BITS'(w_elapsed);
    assign w_dct_ext     = CMP_BITS'(i_dct);
    assign w_stale       = (w_elapsed_ext >= w_dct_ext);
    assign w_within      = (w_elapsed_ext <= w_dct_ext);

    always_comb begin
        case ({i_ctl.was, i_ctl.is_down})
            2'b01:   w_edge = EV_DOWN;
            2'b10:   w_edge = EV_UP;
            2'b11:   w_edge = EV_HELD;
            default: w_edge = EV_NONE;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_start   = r_start;
        o_event   = w_edge;
        w_cnt_clr = (r_count == COUNT_ONE && w_stale) ? COUNT_IDLE : r_count;
        if (w_edge == EV_DOWN) begin
            n_count = (w_cnt_clr < COUNT_TWO) ? w_cnt_clr + COUNT_ONE : w_cnt_clr;
            if (n_count == COUNT_ONE) begin
                n_start = i_now;
            end
        end else if (w_edge == EV_UP) begin
            if (r_count == COUNT_ONE) begin
                n_count = w_cnt_clr;
            end else if (r_count == COUNT_TWO) begin
                if (w_within) begin
                    o_event = EV_DOUBLE;
                end
                n_count = COUNT_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_IDLE;
            r_start <= '0;
        end else if (i_ctl.adv) begin
            r_count <= n_count;
            r_start <= n_start;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("click count out of range");

    a_up_clears_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.adv && w_edge == EV_UP && r_count == COUNT_TWO) |=> r_count == COUNT_IDLE)
        else $error("second release did not clear count");

    a_double_only_on_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event == EV_DOUBLE) |-> (i_ctl.was && !i_ctl.is_down))
        else $error("double click without up edge");

endmodule

### rtl/button_edge_and_double_click.sv
// Top level: button edge and double-click classifier with config register.
`timescale 1ns / 1ps

// Accepts one poll per clock cycle while the output side is ready and
// returns one result beat per poll. A poll is held in an input register;
// the three button classifiers evaluate it and update their click state in
// the cycle it moves into the output register. Time arithmetic is modulo
// 2^TIME_BITS. The double-click interval register resets to 500 ms and is
// written through the configuration channel; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module button_edge_and_double_click
    import bedc_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bedc_in_if.sink     i_in,
    bedc_out_if.source  o_out,
    bedc_cfg_if.sink    i_cfg
);

    localparam int EXT_BITS = (TIME_BITS > STAMP_BITS) ? TIME_BITS : STAMP_BITS;

    logic [STAMP_BITS-1:0]  r_dct;
    logic                   r_s1_valid;
    logic [NUM_BUTTONS-1:0] r_s1_buttons;
    logic [STAMP_BITS-1:0]  r_s1_now;
    logic [NUM_BUTTONS-1:0] r_prev;
    logic                   r_out_valid;
    t_event                 r_ev [NUM_BUTTONS];
    t_event                 w_ev [NUM_BUTTONS];
    logic                   w_out_free;
    logic                   w_adv;
    logic                   w_take;
    logic [EXT_BITS-1:0]    w_now_ext;
    logic [TIME_BITS-1:0]   w_now;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_adv      = r_s1_valid && w_out_free;
    assign i_in.ready = i_rst_n && (!r_s1_valid || w_out_free);
    assign w_take     = i_in.valid && i_in.ready;
    assign i_cfg.ready = i_rst_n;

    assign w_now_ext = EXT_BITS'(r_s1_now);
    assign w_now     = w_now_ext[TIME_BITS-1:0];

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
        t_btn_ctl w_ctl;

        assign w_ctl.was     = r_prev[g];
        assign w_ctl.is_down = r_s1_buttons[g];
        assign w_ctl.adv     = w_adv;

        bedc_button #(
            .TIME_BITS (TIME_BITS)
        ) u_button (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_now   (w_now),
            .i_dct   (r_dct),
            .o_event (w_ev[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dct <= DCT_RESET;
        end else if (i_cfg.valid) begin
            r_dct <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
        end else begin
            if (w_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_prev      <= r_s1_buttons;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_buttons <= i_in.buttons;
            r_s1_now     <= i_in.now_ms;
        end
        if (w_adv) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_ev[b] <= w_ev[b];
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.left_event   = r_ev[0];
    assign o_out.right_event  = r_ev[1];
    assign o_out.middle_event = r_ev[2];

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_take && r_s1_valid && !w_adv))
        else $error("input register overwritten");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced poll did not reach output");

    a_prev_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_prev == $past(r_s1_buttons))
        else $error("previous levels not updated");

    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_ev[0] <= EV_DOUBLE && r_ev[1] <= EV_DOUBLE
                         && r_ev[2] <= EV_DOUBLE))
        else $error("event code out of range");

endmodule
